// ----- hdl/oaht_pkg.sv -----
// types and constants shared by the hash table block
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        RC_INSERTED  = 3'd0,
        RC_UPDATED   = 3'd1,
        RC_REFUSED   = 3'd2,
        RC_FOUND     = 3'd3,
        RC_NOT_FOUND = 3'd4,
        RC_REMOVED   = 3'd5,
        RC_MISSED    = 3'd6
    } rcode_t;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_DELETED  = 2'd2;

    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam logic [1:0] REG_PROBE_MODE  = 2'd0;
    localparam logic [1:0] REG_TABLE_SIZE  = 2'd1;
    localparam logic [1:0] REG_LINEAR_COEF = 2'd2;
    localparam logic [1:0] REG_SQUARE_COEF = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] record_data;
    } req_t;

    typedef struct packed {
        logic [2:0]        result_code;
        logic [DATA_W-1:0] found_data;
        logic [9:0]        slot_index;
        logic [10:0]       probe_collisions;
        logic [10:0]       item_count;
    } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/open_addressing_hash_table.sv -----
// open-addressing hash table with linear, quadratic and double-hash probing
// operation: the key is reduced by bit-serial remainders, then each probe reads,
// waits and evaluates; a full table refuses an insert without probing; slots cleared after reset
// throughput: one item at a time; the next is taken once the result has left
// reset: asynchronous active low, registers to defaults, slot status swept to empty
`timescale 1ns / 1ps
`default_nettype none
module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire req_t        in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rsp_t             out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int DEPTH = 1024;
    localparam int AW    = 10;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DIV    = 10'b0000000100,
        S_START  = 10'b0000001000,
        S_READ   = 10'b0000010000,
        S_WAIT   = 10'b0000100000,
        S_EVAL   = 10'b0001000000,
        S_STEP   = 10'b0010000000,
        S_STEP2  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [10:0] tsize_reg;
    logic [9:0]  lcoef_reg, scoef_reg;

    // slot memories
    logic [1:0]        st_mem  [DEPTH];
    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [DATA_W-1:0] pay_mem [DEPTH];
    logic [1:0]        st_rd_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [DATA_W-1:0] pay_rd_reg;

    // operation registers
    logic [1:0]        func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    logic [10:0]       ts_reg;
    logic [10:0]       r1_reg, r2_reg;     // remainders mod ts and ts-1
    logic [10:0]       rl_reg, rs_reg;     // coefficients mod ts
    logic [5:0]        bit_reg;
    logic [AW-1:0]     addr_reg;           // current probe address
    logic [9:0]        h2_reg;             // double hash stride mod ts
    logic [9:0]        dlin_reg;           // quadratic: first difference
    logic [10:0]       i_reg;              // probe number
    logic [10:0]       coll_reg;
    logic [10:0]       count_reg;
    logic [10:0]       clr_reg;
    logic [9:0]        sq2_reg;            // 2*square_coef mod ts
    logic [9:0]        lin_reg;            // (lin+sq) mod ts
    rsp_t              rsp_reg;
    logic              out_valid_reg;

    // write port controls
    logic              wr_en;
    logic [9:0]        wr_addr;
    logic [1:0]        wr_st;
    logic              wr_kd;

    // modular add of two values below ts
    function automatic logic [9:0] madd(input logic [9:0] a, input logic [9:0] b,
                                       input logic [10:0] m);
        logic [11:0] s;
        s = {2'b0, a} + {2'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[9:0];
    endfunction

    logic [10:0] ts_use;
    assign ts_use = (tsize_reg < 11'd2) ? 11'd2 :
                    (tsize_reg > 11'(DEPTH)) ? 11'(DEPTH) : tsize_reg;

    // bit-serial remainder steps
    logic [11:0] r1_sh, r2_sh, rl_sh, rs_sh;
    logic [10:0] tsm1;
    logic        lbit, sbit;
    assign tsm1  = ts_reg - 11'd1;
    assign r1_sh = {r1_reg, key_reg[KEY_W-1]};
    assign r2_sh = {r2_reg, key_reg[KEY_W-1]};
    assign lbit  = (bit_reg < 6'd10) ? lcoef_reg[bit_reg[3:0]] : 1'b0;
    assign sbit  = (bit_reg < 6'd10) ? scoef_reg[bit_reg[3:0]] : 1'b0;
    assign rl_sh = {rl_reg, lbit};
    assign rs_sh = {rs_reg, sbit};

    logic key_hit;
    assign key_hit = (key_rd_reg == key_reg);

    // probe ends: slot written, empty slot, key match or sequence exhausted
    logic eval_done;
    assign eval_done = wr_en || st_rd_reg == ST_EMPTY
                       || (st_rd_reg == ST_OCCUPIED && key_hit)
                       || (coll_reg + 11'd1 >= ts_reg);

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 2'd0;
            tsize_reg <= 11'd1024;
            lcoef_reg <= 10'd1;
            scoef_reg <= 10'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PROBE_MODE:  mode_reg  <= cfg_data[1:0];
                REG_TABLE_SIZE:  tsize_reg <= cfg_data;
                REG_LINEAR_COEF: lcoef_reg <= cfg_data[9:0];
                REG_SQUARE_COEF: scoef_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            st_mem[wr_addr] <= wr_st;
            if (wr_kd)
            begin
                key_mem[wr_addr] <= key_reg;
                pay_mem[wr_addr] <= data_reg;
            end
        end
        st_rd_reg  <= st_mem[addr_reg];
        key_rd_reg <= key_mem[addr_reg];
        pay_rd_reg <= pay_mem[addr_reg];
    end

    // write port decode
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_st   = ST_OCCUPIED;
        wr_kd   = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[9:0];
            wr_st   = ST_EMPTY;
        end
        else if (state_reg == S_EVAL)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                if (st_rd_reg != ST_OCCUPIED)
                begin
                    wr_en = 1'b1;
                    wr_kd = 1'b1;
                end
                else if (key_hit)
                begin
                    wr_en = 1'b1;
                    wr_kd = 1'b1;
                end
            end
            else if (func_reg == FUNC_REMOVE && st_rd_reg == ST_OCCUPIED && key_hit)
            begin
                wr_en = 1'b1;
                wr_st = ST_DELETED;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == 11'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid && in_ready) state_next = S_DIV;
            S_DIV:   if (bit_reg == 6'd0) state_next = S_START;
            S_START:
                if (func_reg == FUNC_INSERT && count_reg >= ts_reg) state_next = S_OUT;
                else state_next = S_READ;
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_EVAL;
            S_EVAL:  state_next = eval_done ? S_IDLE : S_STEP;
            S_STEP:  state_next = S_STEP2;
            S_STEP2: state_next = S_READ;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= 11'd0;
            count_reg     <= 11'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 11'd1;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_EVAL && wr_en && wr_st == ST_DELETED)
                count_reg <= count_reg - 11'd1;
            else if (state_reg == S_EVAL && wr_en && st_rd_reg != ST_OCCUPIED)
                count_reg <= count_reg + 11'd1;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (state_reg == S_EVAL && eval_done)
                out_valid_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg <= (in_data.func inside {FUNC_INSERT, FUNC_REMOVE}) ? in_data.func
                                                                             : FUNC_SEARCH;
                key_reg  <= in_data.key;
                data_reg <= in_data.record_data;
                ts_reg   <= ts_use;
                r1_reg   <= 11'd0;
                r2_reg   <= 11'd0;
                rl_reg   <= 11'd0;
                rs_reg   <= 11'd0;
                bit_reg  <= 6'(KEY_W - 1);
            end
            S_DIV:
            begin
                // one restoring step for each modulus
                r1_reg  <= (r1_sh >= {1'b0, ts_reg}) ? 11'(r1_sh - {1'b0, ts_reg})
                                                     : r1_sh[10:0];
                r2_reg  <= (r2_sh >= {1'b0, tsm1}) ? 11'(r2_sh - {1'b0, tsm1})
                                                   : r2_sh[10:0];
                rl_reg  <= (rl_sh >= {1'b0, ts_reg}) ? 11'(rl_sh - {1'b0, ts_reg})
                                                     : rl_sh[10:0];
                rs_reg  <= (rs_sh >= {1'b0, ts_reg}) ? 11'(rs_sh - {1'b0, ts_reg})
                                                     : rs_sh[10:0];
                key_reg <= {key_reg[KEY_W-2:0], key_reg[KEY_W-1]};
                bit_reg <= bit_reg - 6'd1;
            end
            S_START:
            begin
                addr_reg <= r1_reg[9:0];
                // stride 1 + key mod (ts-1), at most ts-1
                h2_reg   <= 10'(r2_reg + 11'd1);
                lin_reg  <= madd(rl_reg[9:0], rs_reg[9:0], ts_reg);
                sq2_reg  <= madd(rs_reg[9:0], rs_reg[9:0], ts_reg);
                i_reg    <= 11'd0;
                coll_reg <= 11'd0;
                rsp_reg.result_code      <= RC_REFUSED;
                rsp_reg.found_data       <= '0;
                rsp_reg.slot_index       <= '0;
                rsp_reg.probe_collisions <= '0;
                rsp_reg.item_count       <= count_reg;
            end
            S_READ:
            begin
                // first difference for probe 0->1 is lin+sq
                if (i_reg == 11'd0)
                    dlin_reg <= lin_reg;
            end
            S_EVAL:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (st_rd_reg != ST_OCCUPIED)
                    begin
                        rsp_reg.result_code <= RC_INSERTED;
                        rsp_reg.slot_index  <= addr_reg;
                        rsp_reg.item_count  <= count_reg + 11'd1;
                    end
                    else if (key_hit)
                    begin
                        rsp_reg.result_code <= RC_UPDATED;
                        rsp_reg.slot_index  <= addr_reg;
                        rsp_reg.item_count  <= count_reg;
                    end
                    else
                    begin
                        rsp_reg.result_code <= RC_REFUSED;
                        rsp_reg.probe_collisions <= coll_reg + 11'd1;
                        rsp_reg.item_count  <= count_reg;
                    end
                end
                else
                begin
                    if (st_rd_reg == ST_OCCUPIED && key_hit)
                    begin
                        rsp_reg.slot_index <= addr_reg;
                        if (func_reg == FUNC_REMOVE)
                        begin
                            rsp_reg.result_code <= RC_REMOVED;
                            rsp_reg.item_count  <= count_reg - 11'd1;
                        end
                        else
                        begin
                            rsp_reg.result_code <= RC_FOUND;
                            rsp_reg.found_data  <= pay_rd_reg;
                            rsp_reg.item_count  <= count_reg;
                        end
                    end
                    else
                    begin
                        rsp_reg.result_code <= (func_reg == FUNC_REMOVE) ? RC_MISSED
                                                                         : RC_NOT_FOUND;
                        rsp_reg.item_count  <= count_reg;
                        if (st_rd_reg != ST_EMPTY)
                            rsp_reg.probe_collisions <= coll_reg + 11'd1;
                    end
                end
                coll_reg <= coll_reg + 11'd1;
                i_reg    <= i_reg + 11'd1;
            end
            S_STEP:
            begin
                // next address: add the per-mode increment
                if (mode_reg == MODE_QUAD)
                    addr_reg <= madd(addr_reg, dlin_reg, ts_reg);
                else if (mode_reg == MODE_DOUBLE)
                    addr_reg <= madd(addr_reg, h2_reg, ts_reg);
                else
                    addr_reg <= madd(addr_reg, 10'd1, ts_reg);
            end
            S_STEP2:
            begin
                // quadratic first difference grows by 2*square_coef each probe
                dlin_reg <= madd(dlin_reg, sq2_reg, ts_reg);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
